// ===== rtl/pairwise_heat_conduction_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pairwise heat conduction block
// Concurrent checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_HEAT_CONDUCTION_DEFINES_SVH
`define PAIRWISE_HEAT_CONDUCTION_DEFINES_SVH
`ifndef SYNTH
`define PHC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define PHC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PHC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define PHC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/phc_pkg.sv =====
// ----------------------------------------------------------------------------
// phc_pkg
// Shared constants and types of the heat conduction block.
// ----------------------------------------------------------------------------
package phc_pkg;
    localparam int ENTRIES_DEF   = 1024;
    localparam int WORD_BITS_DEF = 64;
    localparam int FRAC_BITS_DEF = 32;
    localparam int MUL_BITS      = 64;
    localparam int INDEX_BITS    = 10;
    localparam int CFG_BITS      = 63;

    localparam logic [CFG_BITS-1:0] COND_RESET = 63'd214748364;
    localparam logic [CFG_BITS-1:0] STEP_RESET = 63'd4294967296;

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_CONDUCT = 2'd1,
        KIND_READ    = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic {
        REG_COND = 1'b0,
        REG_STEP = 1'b1
    } cfg_reg_t;
endpackage

// ===== rtl/phc_store.sv =====
// ----------------------------------------------------------------------------
// phc_store
// Temperature and area memories, registered reads.
// ----------------------------------------------------------------------------
module phc_store #(
    parameter int ENTRIES   = 1024,
    parameter int WORD_BITS = 64,
    parameter int AW        = 10
) (
    input  logic                 clk,
    input  logic                 t_we,
    input  logic                 a_we,
    input  logic [AW-1:0]        waddr,
    input  logic [WORD_BITS-1:0] t_wdata,
    input  logic [WORD_BITS-1:0] a_wdata,
    input  logic                 rd_en,
    input  logic [AW-1:0]        raddr0,
    input  logic [AW-1:0]        raddr1,
    output logic [WORD_BITS-1:0] t_rdata0,
    output logic [WORD_BITS-1:0] t_rdata1,
    output logic [WORD_BITS-1:0] a_rdata0
);
    logic [WORD_BITS-1:0] temp_mem [ENTRIES];
    logic [WORD_BITS-1:0] area_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            temp_mem[waddr] <= t_wdata;
        end
        if (rd_en)
        begin
            t_rdata0 <= temp_mem[raddr0];
            t_rdata1 <= temp_mem[raddr1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            area_mem[waddr] <= a_wdata;
        end
        if (rd_en)
        begin
            a_rdata0 <= area_mem[raddr0];
        end
    end
endmodule

// ===== rtl/phc_fxmul.sv =====
// ----------------------------------------------------------------------------
// phc_fxmul
// Iterative signed fixed-point multiply, four 33x33 partial products.
// ----------------------------------------------------------------------------
module phc_fxmul #(
    parameter int WORD_BITS = 64,
    parameter int FRAC_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [phc_pkg::MUL_BITS-1:0] op_a,
    input  logic [phc_pkg::MUL_BITS-1:0] op_b,
    output logic                       busy,
    output logic                       done,
    output logic [phc_pkg::MUL_BITS-1:0] result
);
    import phc_pkg::*;

    localparam int SH = MUL_BITS - WORD_BITS;

    logic [MUL_BITS-1:0]   a_reg, b_reg;
    logic [2:0]            step_reg;
    logic                  busy_reg, pv_reg, done_reg;
    logic [1:0]            psh_reg;
    logic signed [65:0]    prod_reg;
    logic [127:0]          acc_reg, acc_next, term;
    logic [MUL_BITS-1:0]   result_reg, slice, wrapped;
    logic signed [32:0]    pa, pb;

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:
            begin
                pa = $signed({1'b0, a_reg[31:0]});
                pb = $signed({1'b0, b_reg[31:0]});
            end
            2'd1:
            begin
                pa = $signed({1'b0, a_reg[31:0]});
                pb = $signed({b_reg[63], b_reg[63:32]});
            end
            2'd2:
            begin
                pa = $signed({a_reg[63], a_reg[63:32]});
                pb = $signed({1'b0, b_reg[31:0]});
            end
            default:
            begin
                pa = $signed({a_reg[63], a_reg[63:32]});
                pb = $signed({b_reg[63], b_reg[63:32]});
            end
        endcase
        term     = 128'(prod_reg) << {psh_reg, 5'b0};
        acc_next = acc_reg + term;
        slice    = acc_next[FRAC_BITS +: MUL_BITS];
        wrapped  = MUL_BITS'($signed(slice << SH) >>> SH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
                pv_reg   <= 1'b0;
            end
            else if (busy_reg)
            begin
                pv_reg   <= !step_reg[2];
                step_reg <= step_reg + 3'd1;
                if (step_reg[2])
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!step_reg[2])
            begin
                prod_reg <= pa * pb;
                psh_reg  <= (step_reg[1:0] == 2'd0) ? 2'd0 :
                            (step_reg[1:0] == 2'd3) ? 2'd2 : 2'd1;
            end
            if (pv_reg)
            begin
                acc_reg <= acc_next;
            end
            if (step_reg[2])
            begin
                result_reg <= wrapped;
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;
endmodule

// ===== rtl/pairwise_heat_conduction.sv =====
// Sequence: load writes the memories in its accept cycle; read goes through
// the registered memory read and ST_RD to the output register; pair: memory
// read, three passes through the shared multiplier, heat latch, two writes.
// Throughput: one item at a time, set by the single iterative multiplier and
// the one write port of the temperature memory; a load does not leave idle.
// Reset: rst_n asynchronous, active low; registers go to k = 0.05, dt = 1.0,
// the memories are not cleared (entries are defined once loaded).
// ----------------------------------------------------------------------------
// pairwise_heat_conduction
// Explicit Fourier conduction step between table entries, sequenced over a
// temperature/area memory and one shared fixed-point multiplier.
// ----------------------------------------------------------------------------
`include "pairwise_heat_conduction_defines.svh"

module pairwise_heat_conduction #(
    parameter int ENTRIES   = phc_pkg::ENTRIES_DEF,
    parameter int WORD_BITS = phc_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = phc_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // input beats
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [9:0] index_a, [19:10] index_b, [83:20] load_temperature,
    // [147:84] load_area, [151:148] zero
    input  logic [151:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]   s_axis_tuser,
    // last_pair
    input  logic         s_axis_tlast,
    // result beats
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] read_temperature, [127:64] read_area
    output logic [127:0] m_axis_tdata,
    // sweep_done
    output logic         m_axis_tlast,
    // register writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [62:0]  cfg_data
);
    import phc_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int W  = WORD_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_PR_LOAD, ST_MUL1, ST_MUL2, ST_MUL3,
        ST_WR_A, ST_WR_B, ST_DONE
    } state_t;

    state_t state_reg;

    logic [CFG_BITS-1:0] cond_reg, step_reg;
    logic                accept, in_a_ok, in_b_ok, out_free;
    kind_t               in_kind;
    logic [INDEX_BITS-1:0] in_ia, in_ib;

    logic [AW-1:0]       ia_reg, ib_reg;
    logic                ok_reg, last_reg;
    logic [W-1:0]        ta_reg, tb_reg;
    logic [MUL_BITS-1:0] diff_reg, heat_reg;

    logic                m_valid_reg, m_valid_next, m_last_reg;
    logic [127:0]        m_data_reg;

    // memory hookup
    logic                t_we, a_we, rd_en;
    logic [AW-1:0]       waddr;
    logic [W-1:0]        t_wdata, rd_ta, rd_tb, rd_area, dw;

    // multiplier hookup
    logic                mul_start, mul_busy, mul_done;
    logic [MUL_BITS-1:0] mul_a, mul_b, mul_res;

    assign in_kind  = kind_t'(s_axis_tuser);
    assign in_ia    = s_axis_tdata[9:0];
    assign in_ib    = s_axis_tdata[19:10];
    assign in_a_ok  = ({22'd0, in_ia} < 32'(ENTRIES));
    assign in_b_ok  = ({22'd0, in_ib} < 32'(ENTRIES));
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign cfg_ready = 1'b1;

    // memory ports: loads write in the accept cycle, pairs write back a then b
    always_comb
    begin
        t_we    = 1'b0;
        a_we    = 1'b0;
        rd_en   = 1'b0;
        waddr   = AW'(in_ia);
        t_wdata = s_axis_tdata[20 +: W];
        if (accept)
        begin
            if (in_kind == KIND_LOAD && in_a_ok)
            begin
                t_we = 1'b1;
                a_we = 1'b1;
            end
            rd_en = (in_kind == KIND_READ) || (in_kind == KIND_CONDUCT);
        end
        else if (state_reg == ST_WR_A)
        begin
            t_we    = 1'b1;
            waddr   = ia_reg;
            t_wdata = ta_reg + heat_reg[W-1:0];
        end
        else if (state_reg == ST_WR_B)
        begin
            t_we    = 1'b1;
            waddr   = ib_reg;
            t_wdata = tb_reg - heat_reg[W-1:0];
        end
    end

    phc_store #(
        .ENTRIES   (ENTRIES),
        .WORD_BITS (W),
        .AW        (AW)
    ) u_store (
        .clk      (clk),
        .t_we     (t_we),
        .a_we     (a_we),
        .waddr    (waddr),
        .t_wdata  (t_wdata),
        .a_wdata  (s_axis_tdata[84 +: W]),
        .rd_en    (rd_en),
        .raddr0   (AW'(in_ia)),
        .raddr1   (AW'(in_ib)),
        .t_rdata0 (rd_ta),
        .t_rdata1 (rd_tb),
        .a_rdata0 (rd_area)
    );

    assign dw = rd_tb - rd_ta;

    // multiplier chain: (k * area) * diff * dt
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = MUL_BITS'($signed(W'({1'b0, cond_reg})));
        mul_b     = MUL_BITS'($signed(rd_area));
        case (state_reg)
            ST_PR_LOAD:
            begin
                mul_start = 1'b1;
            end
            ST_MUL1:
            begin
                mul_start = mul_done;
                mul_a     = mul_res;
                mul_b     = diff_reg;
            end
            ST_MUL2:
            begin
                mul_start = mul_done;
                mul_a     = mul_res;
                mul_b     = MUL_BITS'($signed(W'({1'b0, step_reg})));
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    phc_fxmul #(
        .WORD_BITS (W),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .busy   (mul_busy),
        .done   (mul_done),
        .result (mul_res)
    );

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cond_reg <= COND_RESET;
            step_reg <= STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_COND: cond_reg <= cfg_data;
                REG_STEP: step_reg <= cfg_data;
                default:  cond_reg <= cond_reg;
            endcase
        end
    end

    // output valid: cleared when the beat moves, set when a result is issued
    always_comb
    begin
        m_valid_next = m_valid_reg && !m_axis_tready;
        if ((state_reg == ST_RD || state_reg == ST_DONE) && out_free)
        begin
            m_valid_next = 1'b1;
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_kind)
                            KIND_READ:    state_reg <= ST_RD;
                            KIND_CONDUCT:
                            begin
                                if (in_a_ok && in_b_ok)
                                    state_reg <= ST_PR_LOAD;
                                else if (s_axis_tlast)
                                    state_reg <= ST_DONE;
                            end
                            default:      state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_RD:
                begin
                    if (out_free)
                    begin
                        m_last_reg  <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_PR_LOAD: state_reg <= ST_MUL1;
                ST_MUL1:    if (mul_done) state_reg <= ST_MUL2;
                ST_MUL2:    if (mul_done) state_reg <= ST_MUL3;
                ST_MUL3:    if (mul_done) state_reg <= ST_WR_A;
                ST_WR_A:    state_reg <= ST_WR_B;
                ST_WR_B:    state_reg <= last_reg ? ST_DONE : ST_IDLE;
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_last_reg  <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:    state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ia_reg   <= AW'(in_ia);
            ib_reg   <= AW'(in_ib);
            ok_reg   <= in_a_ok;
            last_reg <= s_axis_tlast;
        end
        if (state_reg == ST_PR_LOAD)
        begin
            ta_reg   <= rd_ta;
            tb_reg   <= rd_tb;
            diff_reg <= MUL_BITS'($signed(dw));
        end
        if (state_reg == ST_MUL3 && mul_done)
        begin
            heat_reg <= mul_res;
        end
        if (state_reg == ST_RD && out_free)
        begin
            m_data_reg <= ok_reg ? {MUL_BITS'($signed(rd_area)), MUL_BITS'($signed(rd_ta))}
                                 : '0;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            m_data_reg <= '0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    // checks
    `PHC_ASSERT_IMP(a_idle_mul, clk, rst_n, s_axis_tready, !mul_busy, "input open while multiplying")
    `PHC_ASSERT_NXT(a_wr_order, clk, rst_n, state_reg == ST_WR_A, state_reg == ST_WR_B, "write b missing")
    `PHC_ASSERT_IMP(a_done_src, clk, rst_n, mul_done, state_reg == ST_MUL1 || state_reg == ST_MUL2 || state_reg == ST_MUL3, "stray multiply done")
endmodule
